>>> rtl/set_assoc_lru_writeback_cache_macros.svh
// Assertion macros shared by the cache RTL.
// Needs nothing else; include by bare file name.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_MACROS_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_MACROS_SVH
// same-cycle implication, masked during reset
`define SLWC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, masked during reset
`define SLWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/slwc_pkg.sv
// Types and constants of the set-associative LRU write-back cache directory.
// Used by slwc_lookup and the top module; depends on nothing.
`default_nettype none
package slwc_pkg;
  localparam int DEFAULT_MAX_SETS = 1024;
  localparam int DEFAULT_MAX_WAYS = 8;
  localparam int TAG_W = 30;
  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  localparam logic [1:0] CFG_WAYS   = 2'd0;
  localparam logic [1:0] CFG_INDEX  = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [1:0] STAT_HIT   = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_EVICT = 2'd2;

  localparam logic [3:0] RST_WAYS   = 4'd4;
  localparam logic [3:0] RST_INDEX  = 4'd6;
  localparam logic [2:0] RST_OFFSET = 3'd5;
  localparam logic [2:0] MIN_OFFSET = 3'd2;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             dirty;
    logic             valid;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef struct packed {
    logic       hit;
    logic       evict;
    logic [1:0] status;
  } look_t;
endpackage
`default_nettype wire

>>> rtl/slwc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module slwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/slwc_lookup.sv
// Set update logic: hit search, fill/victim choice, LRU age update, victim address.
// Depends on slwc_pkg.
`default_nettype none
module slwc_lookup #(
  parameter int MAX_WAYS = slwc_pkg::DEFAULT_MAX_WAYS,
  parameter int WC_W = $clog2(MAX_WAYS + 1)
) (
  input  wire logic                                   func,
  input  wire logic [slwc_pkg::TAG_W-1:0]             tag,
  input  wire logic [31:0]                            set_bits,
  input  wire logic [4:0]                             tag_shift,
  input  wire logic [2:0]                             ob,
  input  wire logic [WC_W-1:0]                        ways,
  input  wire slwc_pkg::line_t [MAX_WAYS-1:0]         row,
  output slwc_pkg::line_t      [MAX_WAYS-1:0]         row_next,
  output slwc_pkg::look_t                             look,
  output logic [31:0]                                 victim
);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic             hit, found;
  logic [WAY_W-1:0] hit_way, free_way, old_way, way;
  logic [slwc_pkg::AGE_W-1:0] best, a;
  slwc_pkg::line_t [MAX_WAYS-1:0] filled;

  always_comb begin
    hit = 1'b0;
    found = 1'b0;
    hit_way = '0;
    free_way = '0;
    old_way = '0;
    best = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways)) begin
        if (!hit && row[w].valid && row[w].tag == tag) begin
          hit = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!found && !row[w].valid) begin
          found = 1'b1;
          free_way = WAY_W'(w);
        end
        if (row[w].age > best) begin
          best = row[w].age;
          old_way = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    look.hit = hit;
    look.evict = 1'b0;
    look.status = slwc_pkg::STAT_HIT;
    victim = '0;
    filled = row;
    if (hit) begin
      way = hit_way;
      if (func == slwc_pkg::FUNC_WRITE) begin
        filled[way].dirty = 1'b1;
      end
    end else begin
      way = found ? free_way : old_way;
      look.status = slwc_pkg::STAT_MISS;
      if (!found && row[old_way].dirty) begin
        look.evict = 1'b1;
        look.status = slwc_pkg::STAT_EVICT;
        victim = ({2'b00, row[old_way].tag} << tag_shift) | (set_bits << ob);
      end
      filled[way].tag = tag;
      filled[way].valid = 1'b1;
      filled[way].dirty = (func == slwc_pkg::FUNC_WRITE);
    end
  end

  // touch: ages not above the accessed way's move up, accessed way becomes youngest
  always_comb begin
    a = filled[way].age;
    row_next = filled;
    if (a != '0) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i < int'(ways) && filled[i].age <= a && filled[i].age < slwc_pkg::AGE_MAX) begin
          row_next[i].age = filled[i].age + 1'b1;
        end
      end
      row_next[way].age = '0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/set_assoc_lru_writeback_cache.sv
// Set-associative LRU write-back, write-allocate cache directory.
// Channels: input item (func, address) on in_valid/in_stall; result item
// (status, victim_address, five event counters) on out_valid/out_stall;
// configuration writes on cfg_valid/cfg_ready with cfg_index and cfg_data.
// Each item is read, then updated: the accepting cycle reads the set row
// from the directory RAM; the lookup state computes hit/fill/victim and LRU
// ages and writes the row back while loading the result register.
// The read-modify-write of one set row stalls new items until it is done.
// After reset the directory's 2**floor(log2(MAX_SETS)) sets (1024 by default)
// are swept one set a cycle, clearing valid and dirty bits and loading ages;
// no item is taken meanwhile. Configuration writes are always taken.
// A stalled result holds; the next item is still accepted and read, but its
// update waits until the result register is free. Counters wrap.
// Depends on slwc_pkg, slwc_ram, slwc_lookup and the macros header.
`default_nettype none
`include "set_assoc_lru_writeback_cache_macros.svh"
module set_assoc_lru_writeback_cache #(
  parameter int MAX_SETS = slwc_pkg::DEFAULT_MAX_SETS,
  parameter int MAX_WAYS = slwc_pkg::DEFAULT_MAX_WAYS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [31:0] address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      victim_address,
  output logic [31:0]      read_count,
  output logic [31:0]      read_miss_count,
  output logic [31:0]      write_count,
  output logic [31:0]      write_miss_count,
  output logic [31:0]      writeback_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  localparam int IDX_W = $clog2(MAX_SETS + 1) - 1;
  localparam int AW = (IDX_W > 0) ? IDX_W : 1;
  localparam int ROWS = 1 << IDX_W;
  localparam int WC_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * $bits(slwc_pkg::line_t);

  slwc_pkg::state_t state, state_next;
  logic [3:0] ways_in_use, set_index_bits;
  logic [2:0] block_offset_bits;
  logic [AW:0] clr_cnt;
  logic        item_func;
  logic [31:0] item_addr;

  logic [WC_W-1:0] ways;
  logic [3:0] ib;
  logic [2:0] ob;
  logic [4:0] tag_shift;
  logic [slwc_pkg::TAG_W-1:0] tag;
  logic [31:0] set_bits;
  logic [AW-1:0] set_addr;

  slwc_pkg::line_t [MAX_WAYS-1:0] row, row_next, clr_row;
  slwc_pkg::look_t look;
  logic [31:0] victim;
  logic accept, finish, ram_we;
  logic [AW-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign finish = (state == slwc_pkg::ST_LOOKUP) && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= slwc_pkg::RST_WAYS;
      set_index_bits <= slwc_pkg::RST_INDEX;
      block_offset_bits <= slwc_pkg::RST_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slwc_pkg::CFG_WAYS:   ways_in_use <= cfg_data;
        slwc_pkg::CFG_INDEX:  set_index_bits <= cfg_data;
        slwc_pkg::CFG_OFFSET: block_offset_bits <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective configuration
  always_comb begin
    if (ways_in_use == 4'd0) ways = WC_W'(1);
    else if (int'(ways_in_use) > MAX_WAYS) ways = WC_W'(MAX_WAYS);
    else ways = WC_W'(ways_in_use);
    ib = (int'(set_index_bits) > IDX_W) ? 4'(IDX_W) : set_index_bits;
    ob = (block_offset_bits < slwc_pkg::MIN_OFFSET) ? slwc_pkg::MIN_OFFSET
                                                   : block_offset_bits;
    tag_shift = 5'(ib) + 5'(ob);
  end

  // tag/set of the item held in the lookup cycle; RAM set address of the input
  always_comb begin
    tag = slwc_pkg::TAG_W'(item_addr >> tag_shift);
    set_bits = (item_addr >> ob) & ((32'd1 << ib) - 32'd1);
    set_addr = AW'((address >> ob) & ((32'd1 << ib) - 32'd1));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= func;
      item_addr <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slwc_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == slwc_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slwc_pkg::ST_CLEAR:
        if (int'(clr_cnt) == ROWS - 1) state_next = slwc_pkg::ST_IDLE;
      slwc_pkg::ST_IDLE:
        if (in_valid) state_next = slwc_pkg::ST_LOOKUP;
      slwc_pkg::ST_LOOKUP:
        if (finish) state_next = slwc_pkg::ST_IDLE;
      default: state_next = slwc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = (state != slwc_pkg::ST_IDLE);
    ram_we = (state == slwc_pkg::ST_CLEAR) || finish;
    for (int w = 0; w < MAX_WAYS; w++) begin
      clr_row[w].age = slwc_pkg::AGE_W'(w);
      clr_row[w].dirty = 1'b0;
      clr_row[w].valid = 1'b0;
      clr_row[w].tag = '0;
    end
    if (state == slwc_pkg::ST_CLEAR) begin
      wr_addr = clr_cnt[AW-1:0];
      wr_data = clr_row;
    end else begin
      wr_addr = AW'(set_bits);
      wr_data = row_next;
    end
  end

  slwc_ram #(.WIDTH(ROW_W), .DEPTH(ROWS), .AW(AW)) u_dir (
    .clk(clk), .wr_en(ram_we), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(accept), .rd_addr(set_addr), .rd_data(rd_data)
  );

  assign row = rd_data;

  slwc_lookup #(.MAX_WAYS(MAX_WAYS), .WC_W(WC_W)) u_lookup (
    .func(item_func), .tag(tag), .set_bits(set_bits), .tag_shift(tag_shift),
    .ob(ob), .ways(ways), .row(row), .row_next(row_next), .look(look),
    .victim(victim)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      read_count <= '0;
      read_miss_count <= '0;
      write_count <= '0;
      write_miss_count <= '0;
      writeback_count <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (finish) begin
        out_valid <= 1'b1;
        if (item_func == slwc_pkg::FUNC_WRITE) begin
          write_count <= write_count + 1'b1;
          if (!look.hit) write_miss_count <= write_miss_count + 1'b1;
        end else begin
          read_count <= read_count + 1'b1;
          if (!look.hit) read_miss_count <= read_miss_count + 1'b1;
        end
        if (look.evict) writeback_count <= writeback_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status <= look.status;
      victim_address <= victim;
    end
  end

  `SLWC_ASSERT_NEXT(a_accept_lookup, clk, rst, accept,
    state == slwc_pkg::ST_LOOKUP, "item not looked up")
  `SLWC_ASSERT_NOW(a_no_overwrite, clk, rst, finish,
    !(out_valid && out_stall), "held result overwritten")
  `SLWC_ASSERT_NOW(a_clear_quiet, clk, rst, state == slwc_pkg::ST_CLEAR,
    !out_valid && in_stall, "activity during clear")
  `SLWC_ASSERT_NOW(a_evict_status, clk, rst, finish && look.evict,
    look.status == slwc_pkg::STAT_EVICT && !look.hit, "evict flag mismatch")
endmodule
`default_nettype wire
